[rtl/core/assert_macros.svh]
// Concurrent assertion helpers for the checker file (slcan_checker.sv).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop on every rising edge of clk while reset (active low) is released.
`define SLC_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Same check, but also evaluated while reset is asserted.
`define SLC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/slcan_pkg.sv]
`default_nettype none

package slcan_pkg;

    localparam int MAX_BYTES     = 8;
    localparam int PAYLOAD_BYTES = 8;
    localparam int STD_ID_DIGITS = 3;
    localparam int EXT_ID_DIGITS = 8;

    localparam logic [7:0] CH_STD_DATA   = 8'h74; // 't'
    localparam logic [7:0] CH_EXT_DATA   = 8'h54; // 'T'
    localparam logic [7:0] CH_STD_REMOTE = 8'h72; // 'r'
    localparam logic [7:0] CH_EXT_REMOTE = 8'h52; // 'R'
    localparam logic [7:0] CH_CR         = 8'h0D; // carriage return

    localparam logic [7:0] HEX_DIGIT_OFS = 8'h30;
    localparam logic [7:0] HEX_ALPHA_OFS = 8'h37;
    localparam logic [3:0] HEX_TEN       = 4'hA;

    typedef struct packed {
        logic [28:0] frame_id;
        logic        is_extended;
        logic        is_remote;
        logic [3:0]  byte_count;
        logic [63:0] payload;
    } in_item_t;

    typedef struct packed {
        logic [7:0] text_char;
        logic       is_last;
    } out_item_t;

endpackage

`default_nettype wire

[rtl/core/slcan_hex.sv]
`default_nettype none

module slcan_hex (
    input  wire logic [3:0] nibble,
    output logic      [7:0] ascii
);
    import slcan_pkg::*;

    always_comb begin
        if (nibble < HEX_TEN) begin
            ascii = {4'h0, nibble} + HEX_DIGIT_OFS;
        end else begin
            ascii = {4'h0, nibble} + HEX_ALPHA_OFS;
        end
    end

endmodule

`default_nettype wire

[rtl/core/slcan_frame_encoder_top.sv]
// After a frame is accepted the sequencer enters ST_LEAD, from which the lead character
// is registered onto the output. A frame yields 6 to 27 characters, one per cycle while
// the result side does not stall, from a single nibble-to-hex unit stepped by the
// sequencer; a new frame is accepted only once the sequencer is back in ST_IDLE.
// Reset: aresetn is synchronous, active low; it idles the sequencer and drops m_valid.
`default_nettype none

module slcan_frame_encoder_top (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire slcan_pkg::in_item_t  s_data,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output slcan_pkg::out_item_t      m_data
);
    import slcan_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LEAD,
        ST_ID,
        ST_LEN,
        ST_DATA,
        ST_CR
    } state_t;

    state_t                          state_reg;
    logic [31:0]                     id_reg;
    logic [8*PAYLOAD_BYTES-1:0]      data_reg;
    logic [3:0]                      len_reg;
    logic [3:0]                      cnt_reg;
    logic                            ext_reg;
    logic                            rtr_reg;
    logic                            m_valid_reg;
    out_item_t                       m_data_reg;

    logic [3:0]                      len_sat;
    logic [8*PAYLOAD_BYTES-1:0]      data_swapped;
    logic [3:0]                      nibble;
    logic [7:0]                      hex_char;
    logic [7:0]                      lead_char;
    out_item_t                       m_data_next;
    logic                            advance;

    slcan_hex u_hex (
        .nibble (nibble),
        .ascii  (hex_char)
    );

    assign len_sat = (s_data.byte_count > 4'(MAX_BYTES)) ? 4'(MAX_BYTES) : s_data.byte_count;

    // Swap nibbles in each byte so each byte's high nibble comes out first.
    always_comb begin
        for (int b = 0; b < PAYLOAD_BYTES; b++) begin
            if (b < MAX_BYTES) begin
                data_swapped[8*b +: 8] = {s_data.payload[8*b +: 4], s_data.payload[8*b+4 +: 4]};
            end else begin
                data_swapped[8*b +: 8] = 8'h00;
            end
        end
    end

    always_comb begin
        priority if (rtr_reg) begin
            lead_char = ext_reg ? CH_EXT_REMOTE : CH_STD_REMOTE;
        end else begin
            lead_char = ext_reg ? CH_EXT_DATA : CH_STD_DATA;
        end
    end

    always_comb begin
        nibble      = data_reg[3:0];
        m_data_next = '{text_char: hex_char, is_last: 1'b0};
        unique case (state_reg)
            ST_ID: begin
                nibble = id_reg[31:28];
            end
            ST_LEN: begin
                nibble = len_reg;
            end
            ST_LEAD: begin
                m_data_next = '{text_char: lead_char, is_last: 1'b0};
            end
            ST_CR: begin
                m_data_next = '{text_char: CH_CR, is_last: 1'b1};
            end
            default: begin
                nibble = data_reg[3:0];
            end
        endcase
    end

    assign advance = (state_reg != ST_IDLE) && (!m_valid_reg || m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            if (state_reg == ST_IDLE) begin
                if (m_ready) begin
                    m_valid_reg <= 1'b0;
                end
                if (s_valid) begin
                    ext_reg  <= s_data.is_extended;
                    rtr_reg  <= s_data.is_remote;
                    len_reg  <= len_sat;
                    data_reg <= data_swapped;
                    if (s_data.is_extended) begin
                        id_reg  <= {3'b000, s_data.frame_id};
                        cnt_reg <= 4'(EXT_ID_DIGITS - 1);
                    end else begin
                        id_reg  <= {s_data.frame_id[4*STD_ID_DIGITS-1:0],
                                    {(32 - 4*STD_ID_DIGITS){1'b0}}};
                        cnt_reg <= 4'(STD_ID_DIGITS - 1);
                    end
                    state_reg <= ST_LEAD;
                end
            end else if (advance) begin
                m_valid_reg <= 1'b1;
                m_data_reg  <= m_data_next;
                unique case (state_reg)
                    ST_LEAD: begin
                        state_reg <= ST_ID;
                    end
                    ST_ID: begin
                        id_reg <= {id_reg[27:0], 4'h0};
                        if (cnt_reg == 4'd0) begin
                            state_reg <= ST_LEN;
                        end else begin
                            cnt_reg <= cnt_reg - 4'd1;
                        end
                    end
                    ST_LEN: begin
                        if (len_reg == 4'd0) begin
                            state_reg <= ST_CR;
                        end else begin
                            cnt_reg   <= 4'({len_reg, 1'b0} - 5'd1);
                            state_reg <= ST_DATA;
                        end
                    end
                    ST_DATA: begin
                        data_reg <= {4'h0, data_reg[8*PAYLOAD_BYTES-1:4]};
                        if (cnt_reg == 4'd0) begin
                            state_reg <= ST_CR;
                        end else begin
                            cnt_reg <= cnt_reg - 4'd1;
                        end
                    end
                    default: begin
                        state_reg <= ST_IDLE;
                    end
                endcase
            end
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

[rtl/core/slcan_checker.sv]
`default_nettype none
`include "assert_macros.svh"

module slcan_checker (
    input wire logic                  aclk,
    input wire logic                  aresetn,
    input wire logic                  s_valid,
    input wire logic                  s_ready,
    input wire logic                  m_valid,
    input wire logic                  m_ready,
    input wire slcan_pkg::out_item_t  m_data
);
    import slcan_pkg::*;

    // One frame at a time: input closes right after an item is taken.
    `SLC_ASSERT(a_busy_after_accept, aclk, aresetn, (s_valid && s_ready) |=> !s_ready, "input ready right after accept")

    `SLC_ASSERT(a_last_is_cr, aclk, aresetn, (m_valid && m_data.is_last) |-> (m_data.text_char == CH_CR), "last flag on non-CR character")

    `SLC_ASSERT(a_cr_is_last, aclk, aresetn, (m_valid && !m_data.is_last) |-> (m_data.text_char != CH_CR), "CR without last flag")

    `SLC_ASSERT(a_out_hold, aclk, aresetn, (m_valid && !m_ready) |=> (m_valid && $stable(m_data)), "stalled result changed")

    // Ready again only after the closing character has been produced.
    `SLC_ASSERT(a_ready_after_cr, aclk, aresetn, ($rose(s_ready)) |-> (m_valid && m_data.is_last), "input reopened before CR")

endmodule

bind slcan_frame_encoder_top slcan_checker u_slcan_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire
